### design/mlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared constants, types and register codes of the ReLU network block.
// ----------------------------------------------------------------------------
package mlp_pkg;

   localparam int MLP_MAX_LAYERS = 4;
   localparam int MLP_MAX_NODES  = 64;
   localparam int MLP_VALUE_BITS = 16;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [2:0] LAYERS_RESET = 3'd2;
   localparam logic [6:0] NODES_RESET  = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_LAYERS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODES0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NODES1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NODES2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NODES3 = 3'd4;

   localparam logic [1:0] KIND_WEIGHT  = 2'd0;
   localparam logic [1:0] KIND_BIAS    = 2'd1;
   localparam logic [1:0] KIND_FEATURE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MAC,
      ST_PAD,
      ST_COPY,
      ST_DONE
   } state_type;

   // control of the activation chain
   typedef struct packed {
      logic load;
      logic rotate;
      logic shift;
      logic feat_we;
      logic copy;
   } cell_ctl_type;

   // one issue slot of the multiply-accumulate pipe
   typedef struct packed {
      logic active;
      logic first;
   } mac_ctl_type;

endpackage

### design/mlp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mlp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/mlp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_cell
// One neuron slot: stored feature, previous-layer activation on a rotating
// ring and current-layer result on a shift line.
// ----------------------------------------------------------------------------
module mlp_cell import mlp_pkg::*; #(
   parameter int VALUE_BITS = MLP_VALUE_BITS,
   parameter int NODE_W     = 6,
   parameter int IDX        = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic [NODE_W-1:0]     feat_row,
   input  logic [VALUE_BITS-1:0] feat_value,
   input  logic [VALUE_BITS-1:0] prev_from,
   input  logic [VALUE_BITS-1:0] cur_from,
   output logic [VALUE_BITS-1:0] prev_out,
   output logic [VALUE_BITS-1:0] cur_out
);

   logic [VALUE_BITS-1:0] feat_ff;
   logic [VALUE_BITS-1:0] prev_ff;
   logic [VALUE_BITS-1:0] cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         feat_ff <= '0;
      end else if (ctl.feat_we && feat_row == NODE_W'(IDX)) begin
         feat_ff <= feat_value;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prev_ff <= feat_ff;
      end else if (ctl.copy) begin
         prev_ff <= cur_ff;
      end else if (ctl.rotate) begin
         prev_ff <= prev_from;
      end
      if (ctl.shift) begin
         cur_ff <= cur_from;
      end
   end

   assign prev_out = prev_ff;
   assign cur_out  = cur_ff;

endmodule

### design/mlp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_mac
// Three-stage multiply-accumulate with bias preload, ReLU and saturation.
// ----------------------------------------------------------------------------
module mlp_mac import mlp_pkg::*; #(
   parameter int VALUE_BITS = MLP_VALUE_BITS,
   parameter int ACC_W      = 40
) (
   input  logic                  clock,
   input  mac_ctl_type           issue,
   input  logic [VALUE_BITS-1:0] act,
   input  logic [VALUE_BITS-1:0] weight,
   input  logic [VALUE_BITS-1:0] bias,
   input  logic                  bias_valid,
   output logic [VALUE_BITS-1:0] result
);

   localparam logic signed [ACC_W-1:0] TOP =
      ACC_W'((64'd1 << (VALUE_BITS - 1)) - 64'd1);

   mac_ctl_type                    a_ff, b_ff;
   logic signed [VALUE_BITS-1:0]   act_ff;
   logic signed [VALUE_BITS-1:0]   bias_ff;
   logic signed [2*VALUE_BITS-1:0] prod_ff;
   logic signed [ACC_W-1:0]        acc_ff;
   logic signed [ACC_W-1:0]        acc_in;
   logic signed [ACC_W-1:0]        shifted;

   always_ff @(posedge clock) begin
      a_ff   <= issue;
      act_ff <= act;
      b_ff   <= a_ff;
      prod_ff <= $signed(weight) * act_ff;
      if (a_ff.first) begin
         bias_ff <= bias_valid ? $signed(bias) : '0;
      end
      acc_ff <= acc_in;
   end

   always_comb begin
      acc_in = b_ff.first ? (ACC_W'(bias_ff) <<< 8) : acc_ff;
      if (b_ff.active) begin
         acc_in = acc_in + ACC_W'(prod_ff);
      end
   end

   always_comb begin
      shifted = acc_ff >>> 8;
      if (acc_ff < 0) begin
         result = '0;
      end else if (shifted > TOP) begin
         result = TOP[VALUE_BITS-1:0];
      end else begin
         result = shifted[VALUE_BITS-1:0];
      end
   end

endmodule

### design/mlp_relu_inference_argmax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_relu_inference_argmax
// Fully connected ReLU network with argmax over the final layer.
//
//   channel  dir  handshake          payload
//   req      in   tvalid/tready      tuser kind, tlast last, tdata fields
//   rsp      out  tvalid/tready      tdata class_index, class_score
//   csr      in   we                 index, wdata
//
// Weight, bias and feature items are taken while the block is idle. A feature
// item with last starts a forward pass: each neuron is worked out on the single
// MAC while the activation ring makes a full turn, unused neuron slots are then
// padded, and a copy step closes each layer. Input is held off during the
// pass; a finished result waits in the output register while loading goes on.
// Reset is synchronous; features and biases read as zero after reset.
// ----------------------------------------------------------------------------
module mlp_relu_inference_argmax import mlp_pkg::*; #(
   parameter int MAX_LAYERS = MLP_MAX_LAYERS,
   parameter int MAX_NODES  = MLP_MAX_NODES,
   parameter int VALUE_BITS = MLP_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // layer_sel, row_index, col_index, value
   input  logic [1:0]            req_tuser,  // kind
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // class_index, class_score
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int LAYER_W = $clog2(MAX_LAYERS);
   localparam int NCNT_W  = $clog2(MAX_NODES + 1);
   localparam int LCNT_W  = $clog2(MAX_LAYERS + 1);
   localparam int K_W     = $clog2(MAX_NODES + 3);
   localparam int ACC_W   = 2 * VALUE_BITS + NODE_W + 2;
   localparam int WADDR_W = LAYER_W + 2 * NODE_W;
   localparam int BADDR_W = LAYER_W + NODE_W;

   // field unpacking
   logic [1:0]  f_kind, f_lsel;
   logic [5:0]  f_row, f_col;
   logic [15:0] f_value;
   logic [NODE_W+5:0]  row_x, col_x;
   logic [LAYER_W+1:0] lsel_x;
   logic [VALUE_BITS+15:0] value_x;
   logic [VALUE_BITS-1:0]  value_v;
   logic row_ok, col_ok, lsel_ok, accept;

   assign f_lsel  = req_tdata[1:0];
   assign f_row   = req_tdata[7:2];
   assign f_col   = req_tdata[13:8];
   assign f_value = req_tdata[29:14];
   assign f_kind  = req_tuser;
   assign row_x   = (NODE_W + 6)'(f_row);
   assign col_x   = (NODE_W + 6)'(f_col);
   assign lsel_x  = (LAYER_W + 2)'(f_lsel);
   assign value_x = (VALUE_BITS + 16)'($signed(f_value));
   assign value_v = value_x[VALUE_BITS-1:0];
   assign row_ok  = int'(row_x) < MAX_NODES;
   assign col_ok  = int'(col_x) < MAX_NODES;
   assign lsel_ok = int'(lsel_x) < MAX_LAYERS;
   assign accept  = req_tvalid && req_tready;

   // configuration registers
   logic [2:0] layers_ff;
   logic [6:0] nodes_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         layers_ff <= LAYERS_RESET;
         for (int i = 0; i < 4; i++) begin
            nodes_ff[i] <= NODES_RESET;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LAYERS: layers_ff   <= csr_wdata[2:0];
            CSR_NODES0: nodes_ff[0] <= csr_wdata;
            CSR_NODES1: nodes_ff[1] <= csr_wdata;
            CSR_NODES2: nodes_ff[2] <= csr_wdata;
            CSR_NODES3: nodes_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic logic [NCNT_W-1:0] clamp_nodes(input logic [6:0] raw);
      logic [NCNT_W-1:0] r;
      if (raw == 7'd0) begin
         r = NCNT_W'(1);
      end else if (int'(raw) > MAX_NODES) begin
         r = NCNT_W'(MAX_NODES);
      end else begin
         r = NCNT_W'(raw);
      end
      return r;
   endfunction

   // sequencer registers
   state_type state_ff, state_in;
   logic [LCNT_W-1:0] layer_ff, layer_in, nl;
   logic [NCNT_W-1:0] j_ff, j_in, nprev_ff, nprev_in, ncur;
   logic [K_W-1:0]    k_ff, k_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic [NODE_W-1:0]     idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   always_comb begin
      if (layers_ff < 3'd2) begin
         nl = LCNT_W'(2);
      end else if (int'(layers_ff) > MAX_LAYERS) begin
         nl = LCNT_W'(MAX_LAYERS);
      end else begin
         nl = LCNT_W'(layers_ff);
      end
      if (int'(layer_ff) < 4) begin
         ncur = clamp_nodes(nodes_ff[layer_ff[1:0]]);
      end else begin
         ncur = NCNT_W'(MAX_NODES);
      end
   end

   // stores
   logic w_we, b_we;
   logic [VALUE_BITS-1:0] w_q, b_q;
   logic [WADDR_W-1:0] w_waddr, w_raddr;
   logic [BADDR_W-1:0] b_waddr, b_raddr;
   logic [MAX_LAYERS*MAX_NODES-1:0] bvld_ff;
   logic bvld_q_ff;

   assign w_we    = accept && f_kind == KIND_WEIGHT && lsel_ok && row_ok && col_ok;
   assign b_we    = accept && f_kind == KIND_BIAS && lsel_ok && row_ok;
   assign w_waddr = {lsel_x[LAYER_W-1:0], row_x[NODE_W-1:0], col_x[NODE_W-1:0]};
   assign b_waddr = {lsel_x[LAYER_W-1:0], row_x[NODE_W-1:0]};
   assign w_raddr = {layer_ff[LAYER_W-1:0], j_ff[NODE_W-1:0], k_ff[NODE_W-1:0]};
   assign b_raddr = {layer_ff[LAYER_W-1:0], j_ff[NODE_W-1:0]};

   mlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LAYERS * MAX_NODES * MAX_NODES)) u_weights (
      .clock (clock),
      .we    (w_we),
      .waddr (w_waddr),
      .wdata (value_v),
      .raddr (w_raddr),
      .rdata (w_q)
   );

   mlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LAYERS * MAX_NODES)) u_biases (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (value_v),
      .raddr (b_raddr),
      .rdata (b_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bvld_ff <= '0;
      end else if (b_we) begin
         bvld_ff[b_waddr] <= 1'b1;
      end
      bvld_q_ff <= bvld_ff[b_raddr];
   end

   // activation chain
   cell_ctl_type ctl;
   logic [VALUE_BITS-1:0] prev_v [MAX_NODES];
   logic [VALUE_BITS-1:0] cur_v  [MAX_NODES];
   logic [VALUE_BITS-1:0] tail_value, mac_result;
   mac_ctl_type issue;

   for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
      mlp_cell #(.VALUE_BITS(VALUE_BITS), .NODE_W(NODE_W), .IDX(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .feat_row   (row_x[NODE_W-1:0]),
         .feat_value (value_v),
         .prev_from  (prev_v[(i + 1) % MAX_NODES]),
         .cur_from   ((i == MAX_NODES - 1) ? tail_value : cur_v[(i + 1) % MAX_NODES]),
         .prev_out   (prev_v[i]),
         .cur_out    (cur_v[i])
      );
   end

   mlp_mac #(.VALUE_BITS(VALUE_BITS), .ACC_W(ACC_W)) u_mac (
      .clock      (clock),
      .issue      (issue),
      .act        (prev_v[0]),
      .weight     (w_q),
      .bias       (b_q),
      .bias_valid (bvld_q_ff),
      .result     (mac_result)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      layer_ff    <= layer_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      nprev_ff    <= nprev_in;
      best_ff     <= best_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      layer_in     = layer_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      nprev_in     = nprev_ff;
      best_in      = best_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ctl          = '0;
      issue        = '0;
      tail_value   = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            ctl.feat_we = accept && f_kind == KIND_FEATURE && row_ok;
            if (accept && f_kind == KIND_FEATURE && req_tlast) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctl.load = 1'b1;
            layer_in = LCNT_W'(1);
            nprev_in = clamp_nodes(nodes_ff[0]);
            j_in     = '0;
            k_in     = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (int'(k_ff) < MAX_NODES) begin
               ctl.rotate   = 1'b1;
               issue.active = k_ff < K_W'(nprev_ff);
               issue.first  = k_ff == '0;
            end
            k_in = k_ff + K_W'(1);
            if (int'(k_ff) == MAX_NODES + 2) begin
               k_in       = '0;
               ctl.shift  = 1'b1;
               tail_value = mac_result;
               if (j_ff == '0 || mac_result > best_ff) begin
                  best_in = mac_result;
                  idx_in  = j_ff[NODE_W-1:0];
               end
               j_in = j_ff + NCNT_W'(1);
               if (j_ff + NCNT_W'(1) == ncur) begin
                  state_in = (int'(ncur) < MAX_NODES) ? ST_PAD : ST_COPY;
               end
            end
         end
         ST_PAD: begin
            ctl.shift = 1'b1;
            j_in      = j_ff + NCNT_W'(1);
            if (int'(j_ff) + 1 == MAX_NODES) begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            ctl.copy = 1'b1;
            nprev_in = ncur;
            j_in     = '0;
            k_in     = '0;
            if (layer_ff + LCNT_W'(1) == nl) begin
               state_in = ST_DONE;
            end else begin
               layer_in = layer_ff + LCNT_W'(1);
               state_in = ST_MAC;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({15'(best_ff), 6'(idx_ff)});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### tb/mlp_argmax_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_argmax_checker
// Watches the item, result and register ports of the ReLU network block. It
// keeps its own copy of the weight, bias and feature tables and of the layer
// set-up, and works out the winning class and score for every feature item
// that carries last. Each result is compared field by field with the oldest
// class still awaited.
// ----------------------------------------------------------------------------
module mlp_argmax_checker import mlp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    classes_awaited
);

   typedef struct {
      logic [5:0]  class_index;
      logic [14:0] class_score;
   } class_result_type;

   shortint          weights [0:MLP_MAX_LAYERS*MLP_MAX_NODES*MLP_MAX_NODES-1];
   shortint          biases [0:MLP_MAX_LAYERS*MLP_MAX_NODES-1];
   shortint          features [0:MLP_MAX_NODES-1];
   logic [2:0]       layer_reg;
   logic [6:0]       node_reg [0:3];
   class_result_type expected_classes [$];

   function automatic int clamp_nodes(logic [6:0] raw);
      if (raw == 0) return 1;
      if (raw > MLP_MAX_NODES) return MLP_MAX_NODES;
      return int'(raw);
   endfunction

   function automatic class_result_type predict_class();
      int               prev [MLP_MAX_NODES];
      int               cur [MLP_MAX_NODES];
      int               nl, nprev, ncur, best;
      longint           acc;
      class_result_type res;
      nl = (layer_reg < 2) ? 2 :
           (layer_reg > MLP_MAX_LAYERS) ? MLP_MAX_LAYERS : int'(layer_reg);
      nprev = clamp_nodes(node_reg[0]);
      for (int k = 0; k < MLP_MAX_NODES; k++) prev[k] = features[k];
      ncur = nprev;
      for (int l = 1; l < nl; l++) begin
         ncur = clamp_nodes(node_reg[l]);
         for (int j = 0; j < ncur; j++) begin
            acc = longint'(biases[l*MLP_MAX_NODES+j]) * 256;
            for (int k = 0; k < nprev; k++)
               acc += longint'(weights[(l*MLP_MAX_NODES+j)*MLP_MAX_NODES+k]) *
                      longint'(prev[k]);
            if (acc < 0) cur[j] = 0;
            else if ((acc >>> 8) > 32767) cur[j] = 32767;
            else cur[j] = int'(acc >>> 8);
         end
         for (int j = 0; j < MLP_MAX_NODES; j++) prev[j] = cur[j];
         nprev = ncur;
      end
      best = 0;
      for (int j = 1; j < ncur; j++)
         if (prev[j] > prev[best]) best = j;
      res.class_index = best[5:0];
      res.class_score = prev[best][14:0];
      return res;
   endfunction

   always @(posedge clock) begin
      class_result_type exp_res;
      logic [1:0]       lsel;
      logic [5:0]       row, col;
      if (reset) begin
         for (int i = 0; i < MLP_MAX_LAYERS*MLP_MAX_NODES; i++) biases[i] = 0;
         for (int i = 0; i < MLP_MAX_NODES; i++) features[i] = 0;
         layer_reg = LAYERS_RESET;
         for (int i = 0; i < 4; i++) node_reg[i] = NODES_RESET;
         expected_classes.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LAYERS: layer_reg = csr_wdata[2:0];
               CSR_NODES0: node_reg[0] = csr_wdata;
               CSR_NODES1: node_reg[1] = csr_wdata;
               CSR_NODES2: node_reg[2] = csr_wdata;
               CSR_NODES3: node_reg[3] = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_classes.size() == 0) begin
               $error("unexpected result item: class_index %0d class_score %0d",
                      rsp_tdata[5:0], rsp_tdata[20:6]);
               fail_count <= fail_count + 1;
            end else begin
               exp_res = expected_classes.pop_front();
               if (rsp_tdata[5:0] !== exp_res.class_index ||
                   rsp_tdata[20:6] !== exp_res.class_score) begin
                  if (rsp_tdata[5:0] !== exp_res.class_index)
                     $error("class_index expected %0d actual %0d",
                            exp_res.class_index, rsp_tdata[5:0]);
                  if (rsp_tdata[20:6] !== exp_res.class_score)
                     $error("class_score expected %0d actual %0d",
                            exp_res.class_score, rsp_tdata[20:6]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            lsel = req_tdata[1:0];
            row  = req_tdata[7:2];
            col  = req_tdata[13:8];
            case (req_tuser)
               KIND_WEIGHT:
                  weights[(lsel*MLP_MAX_NODES+row)*MLP_MAX_NODES+col] = req_tdata[29:14];
               KIND_BIAS: biases[lsel*MLP_MAX_NODES+row] = req_tdata[29:14];
               KIND_FEATURE: begin
                  features[row] = req_tdata[29:14];
                  if (req_tlast) expected_classes.push_back(predict_class());
               end
               default: ;
            endcase
         end
      end
      classes_awaited <= expected_classes.size();
   end

endmodule

### tb/tb_mlp_relu_inference_argmax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mlp_relu_inference_argmax
// Drives the ReLU network block through a series of layer set-ups, from the
// smallest to full width, with directed saturation, tie and ignored-item
// cases first and then random load and inference sequences mixed with noise.
// Every weight a pass reads is written beforehand. Both ports idle at random.
// ----------------------------------------------------------------------------
module tb_mlp_relu_inference_argmax import mlp_pkg::*; ();

   localparam int CYCLE_LIMIT = 200000000;
   localparam logic [1:0] KIND_NONE = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // layer_sel, row_index, col_index, value
   logic [1:0]            req_tuser;   // kind
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // class_index, class_score
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    classes_awaited;

   bit                    weight_written [0:MLP_MAX_LAYERS*MLP_MAX_NODES*MLP_MAX_NODES-1];
   logic [2:0]            layer_cfg;
   logic [6:0]            node_cfg [0:3];
   bit                    no_gaps;
   int                    stall_left = 0;
   int                    cycle_count = 0;

   mlp_relu_inference_argmax DUT (.*);

   mlp_argmax_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [15:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2, 3: return 16'($urandom);
         default: return 16'($urandom_range(0, 1023) - 512);
      endcase
   endfunction

   function automatic int nodes_of(int l);
      if (node_cfg[l] == 0) return 1;
      if (node_cfg[l] > MLP_MAX_NODES) return MLP_MAX_NODES;
      return int'(node_cfg[l]);
   endfunction

   function automatic int layers_eff();
      if (layer_cfg < 2) return 2;
      if (layer_cfg > MLP_MAX_LAYERS) return MLP_MAX_LAYERS;
      return int'(layer_cfg);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_gaps) stall_left <= gap_len();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] kind, input logic [1:0] lsel,
                            input logic [5:0] row, input logic [5:0] col,
                            input logic [15:0] val, input logic last);
      int gap;
      gap = no_gaps ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tlast  <= last;
      req_tdata  <= {2'b00, val, col, row, lsel};
      @(posedge clock iff req_tready);
      if (kind == KIND_WEIGHT) weight_written[(lsel*MLP_MAX_NODES+row)*MLP_MAX_NODES+col] = 1'b1;
   endtask

   // make sure every weight the next pass reads has been written
   task automatic fill_weights();
      int nl;
      nl = layers_eff();
      for (int l = 1; l < nl; l++)
         for (int j = 0; j < nodes_of(l); j++)
            for (int k = 0; k < nodes_of(l-1); k++)
               if (!weight_written[(l*MLP_MAX_NODES+j)*MLP_MAX_NODES+k])
                  send_item(KIND_WEIGHT, 2'(l), 6'(j), 6'(k), rand_value(),
                            1'($urandom_range(0, 1)));
   endtask

   task automatic put(input logic [1:0] kind, input logic [1:0] lsel, input logic [5:0] row,
                      input logic [5:0] col, input logic [15:0] val, input logic last);
      if (kind == KIND_FEATURE && last) fill_weights();
      send_item(kind, lsel, row, col, val, last);
   endtask

   task automatic set_layers(input logic [2:0] nl, input logic [6:0] n0, input logic [6:0] n1,
                             input logic [6:0] n2, input logic [6:0] n3);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (classes_awaited != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      layer_cfg = nl;
      node_cfg[0] = n0;
      node_cfg[1] = n1;
      node_cfg[2] = n2;
      node_cfg[3] = n3;
      csr_we <= 1'b1;
      csr_index <= CSR_LAYERS;
      csr_wdata <= {4'b0000, nl};
      @(posedge clock);
      csr_index <= CSR_NODES0;
      csr_wdata <= n0;
      @(posedge clock);
      csr_index <= CSR_NODES1;
      csr_wdata <= n1;
      @(posedge clock);
      csr_index <= CSR_NODES2;
      csr_wdata <= n2;
      @(posedge clock);
      csr_index <= CSR_NODES3;
      csr_wdata <= n3;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_items(input int target);
      int sent, nl, l, nf, n0;
      sent = 0;
      nl = layers_eff();
      n0 = nodes_of(0);
      while (sent < target) begin
         if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(0, 6)) begin
               l = $urandom_range(1, nl - 1);
               if ($urandom_range(0, 2) == 0)
                  put(KIND_BIAS, 2'(l), 6'($urandom_range(0, nodes_of(l) - 1)), 6'($urandom),
                      rand_value(), 1'($urandom_range(0, 1)));
               else
                  put(KIND_WEIGHT, 2'(l), 6'($urandom_range(0, nodes_of(l) - 1)),
                      6'($urandom_range(0, nodes_of(l-1) - 1)), rand_value(),
                      1'($urandom_range(0, 1)));
               sent++;
            end
            nf = $urandom_range(1, (n0 < 8) ? n0 : 8);
            for (int f = 0; f < nf; f++) begin
               put(KIND_FEATURE, 2'($urandom), 6'($urandom_range(0, n0 - 1)), 6'($urandom),
                   rand_value(), f == nf - 1);
               sent++;
            end
         end else begin
            put(2'($urandom), 2'($urandom), 6'($urandom), 6'($urandom), 16'($urandom),
                $urandom_range(0, 7) == 0);
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      no_gaps = 1'b0;
      layer_cfg = LAYERS_RESET;
      for (int i = 0; i < 4; i++) node_cfg[i] = NODES_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, ignored items, saturation and ties
      set_layers(3'd4, 7'd2, 7'd3, 7'd2, 7'd3);
      put(KIND_WEIGHT, 2'd0, 6'd0, 6'd0, 16'h7fff, 1'b0);
      put(KIND_BIAS, 2'd0, 6'd63, 6'd0, 16'h8000, 1'b1);
      put(KIND_BIAS, 2'd1, 6'd0, 6'd0, 16'h7fff, 1'b0);
      put(KIND_BIAS, 2'd1, 6'd1, 6'd0, 16'h8000, 1'b0);
      put(KIND_WEIGHT, 2'd1, 6'd0, 6'd0, 16'h7fff, 1'b1);
      put(KIND_WEIGHT, 2'd1, 6'd0, 6'd1, 16'h8000, 1'b0);
      put(KIND_NONE, 2'd3, 6'd63, 6'd63, 16'hffff, 1'b1);
      put(KIND_FEATURE, 2'd0, 6'd0, 6'd0, 16'h7fff, 1'b0);
      put(KIND_FEATURE, 2'd3, 6'd1, 6'd63, 16'h8000, 1'b1);
      for (int j = 0; j < 3; j++) begin
         put(KIND_BIAS, 2'd3, 6'(j), 6'd0, 16'h0000, 1'b0);
         for (int k = 0; k < 2; k++) put(KIND_WEIGHT, 2'd3, 6'(j), 6'(k), 16'h0000, 1'b0);
      end
      put(KIND_FEATURE, 2'd0, 6'd0, 6'd0, 16'h0100, 1'b1);
      put(KIND_BIAS, 2'd3, 6'd1, 6'd0, 16'h0005, 1'b0);
      put(KIND_BIAS, 2'd3, 6'd2, 6'd0, 16'h0005, 1'b0);
      put(KIND_FEATURE, 2'd0, 6'd0, 6'd0, 16'h0100, 1'b1);

      set_layers(3'd2, 7'd1, 7'd1, 7'd1, 7'd1);
      random_items(40);
      set_layers(3'd0, 7'd0, 7'd127, 7'd5, 7'd5);
      random_items(30);
      set_layers(3'd7, 7'd8, 7'd6, 7'd7, 7'd5);
      random_items(60);
      set_layers(3'd2, 7'd64, 7'd2, 7'd1, 7'd1);
      random_items(20);
      set_layers(3'd4, 7'd64, 7'd1, 7'd64, 7'd1);
      random_items(20);
      for (int p = 0; p < 10; p++) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         set_layers(3'($urandom), 7'($urandom_range(0, 8)), 7'($urandom_range(0, 8)),
                    7'($urandom_range(0, 8)), 7'($urandom_range(0, 8)));
         random_items(150);
      end
      no_gaps = 1'b0;

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (classes_awaited != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
